// File: rtl/svna_pkg.sv
// shared constants and types for the smooth vertex normal accumulator
package svna_pkg;

  localparam int MAX_VERTS_DEF = 4096;
  localparam int POS_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF = 24;

  // magnitude width of a vector handed to the normaliser (cross product up to 2^61)
  localparam int MW = 62;
  // quotient width of one normalised component (at most 16384)
  localparam int QW = 15;
  // edge magnitude width (holds the difference of two 24-bit positions)
  localparam int EMW = 33;

  typedef logic [1:0] func_t;
  localparam func_t FN_STORE = 2'd0;
  localparam func_t FN_TRI   = 2'd1;
  localparam func_t FN_READ  = 2'd2;
  localparam func_t FN_CLEAR = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_ZERO  = 2'd2;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

// File: rtl/svna_norm.sv
// iterative vector normaliser: common shrink, sum of squares, square root, rounded divide
module svna_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [svna_pkg::MW-1:0] mag_in [3],
  output svna_pkg::norm_stat_t   stat,
  output logic [svna_pkg::QW-1:0] q [3]
);
  import svna_pkg::*;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHR   = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_CHK   = 7'b0001000,
    N_SQRT  = 7'b0010000,
    N_DLOAD = 7'b0100000,
    N_DIV   = 7'b1000000
  } nstate_t;

  nstate_t       state;
  logic          done;
  logic          zero;
  logic [MW-1:0] m [3];
  logic [1:0]    sq_cnt;
  logic [29:0]   sq_op;
  logic [59:0]   sprod;
  logic [61:0]   sum;
  logic [62:0]   s_rem;
  logic [62:0]   root;
  logic [62:0]   root_next;
  logic [62:0]   trial;
  logic [61:0]   bitv;
  logic [30:0]   len;
  logic [1:0]    comp;
  logic [3:0]    dcnt;
  logic [31:0]   rem;
  logic [31:0]   dtrial;
  logic [14:0]   low;
  logic [QW-1:0] qacc;
  logic [44:0]   num;
  logic          qb;

  assign stat.done = done;
  assign stat.zero = zero;

  always_comb begin
    case (sq_cnt)
      2'd0:    sq_op = m[0][29:0];
      2'd1:    sq_op = m[1][29:0];
      2'd2:    sq_op = m[2][29:0];
      default: sq_op = '0;
    endcase
  end

  assign trial = root + 63'(bitv);
  always_comb begin
    if (s_rem >= trial) begin
      root_next = (root >> 1) + 63'(bitv);
    end else begin
      root_next = root >> 1;
    end
  end

  assign num    = {m[comp][29:0], 14'd0} + 45'(len >> 1);
  assign dtrial = {rem[30:0], low[14]};
  assign qb     = (dtrial >= {1'b0, len});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      zero  <= 1'b0;
    end else begin
      case (state)
        N_IDLE: begin
          done <= 1'b0;
          if (start) begin
            m[0]  <= mag_in[0];
            m[1]  <= mag_in[1];
            m[2]  <= mag_in[2];
            zero  <= 1'b0;
            state <= N_SHR;
          end
        end
        N_SHR: begin
          if ((|m[0][MW-1:30]) || (|m[1][MW-1:30]) || (|m[2][MW-1:30])) begin
            m[0] <= m[0] >> 1;
            m[1] <= m[1] >> 1;
            m[2] <= m[2] >> 1;
          end else begin
            sq_cnt <= '0;
            sum    <= '0;
            state  <= N_SQ;
          end
        end
        N_SQ: begin
          sprod <= sq_op * sq_op;
          if (sq_cnt != 2'd0) begin
            sum <= sum + 62'(sprod);
          end
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) begin
            state <= N_CHK;
          end
        end
        N_CHK: begin
          if (sum == '0) begin
            zero  <= 1'b1;
            done  <= 1'b1;
            state <= N_IDLE;
          end else begin
            s_rem <= 63'(sum);
            root  <= '0;
            bitv  <= 62'd1 << 60;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (s_rem >= trial) begin
            s_rem <= s_rem - trial;
          end
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv == 62'd1) begin
            len   <= root_next[30:0];
            comp  <= '0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem   <= 32'(num[44:15]);
          low   <= num[14:0];
          dcnt  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          rem  <= qb ? (dtrial - {1'b0, len}) : dtrial;
          low  <= low << 1;
          qacc <= {qacc[QW-2:0], qb};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd14) begin
            q[comp] <= {qacc[QW-2:0], qb};
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DLOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/smooth_vertex_normal_accumulator.sv
// top level: smooth per-vertex normals from averaged unit face normals
//
// Input channel (in_valid/in_ready) takes one command beat: store a position,
// add a triangle, read a normal or clear the accumulators. Every beat gives
// exactly one result beat (status, norm_x/y/z) on out_valid/out_ready.
// One command is worked on at a time; in_ready is high while the block is idle,
// and a finished result waits in the output register without holding that up.
// Work per command, set by the sequencer around the position and accumulator
// memories and the bit-serial normaliser (shrink loop, 31-step square root,
// 15-step divide per component):
//   store position or rejected index: straight to the result
//   add triangle: three position reads, edge shrink, six products through one
//     multiplier, normaliser, three read-modify-writes (none for a degenerate face)
//   read normal: accumulator read and normaliser; for a zero-length accumulator or
//     degenerate face the normaliser stops after the sum of squares
//   clear: one accumulator entry per cycle
// After reset a pass over all MAX_VERTS accumulator entries zeroes them, during
// which no command is taken; vertex_count may be written at any time it is idle.
// A stalled receiver holds the result; the next command may already run and
// its result waits until the output register is free.
module smooth_vertex_normal_accumulator #(
  parameter int MAX_VERTS = svna_pkg::MAX_VERTS_DEF,
  parameter int POS_WIDTH = svna_pkg::POS_WIDTH_DEF,
  parameter int ACC_WIDTH = svna_pkg::ACC_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  svna_pkg::func_t     func,
  input  logic [11:0]         vertex_index,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [23:0]  pos_z,
  input  logic [11:0]         corner_a,
  input  logic [11:0]         corner_b,
  input  logic [11:0]         corner_c,
  output logic                out_valid,
  input  logic                out_ready,
  output svna_pkg::status_t   status,
  output logic signed [15:0]  norm_x,
  output logic signed [15:0]  norm_y,
  output logic signed [15:0]  norm_z
);
  import svna_pkg::*;

  localparam int AW = $clog2(MAX_VERTS);
  localparam int PW = POS_WIDTH;
  localparam int A  = ACC_WIDTH;

  typedef enum logic [12:0] {
    T_CLEAR  = 13'b0000000000001,
    T_IDLE   = 13'b0000000000010,
    T_PRD    = 13'b0000000000100,
    T_EDGE   = 13'b0000000001000,
    T_ESHR   = 13'b0000000010000,
    T_CROSS  = 13'b0000000100000,
    T_CMAG   = 13'b0000001000000,
    T_NSTART = 13'b0000010000000,
    T_NWAIT  = 13'b0000100000000,
    T_ARD    = 13'b0001000000000,
    T_AGET   = 13'b0010000000000,
    T_AWR    = 13'b0100000000000,
    T_RESULT = 13'b1000000000000
  } tstate_t;

  tstate_t state;

  // storage
  logic [3*PW-1:0] pos_mem [MAX_VERTS];
  logic [3*A-1:0]  acc_mem [MAX_VERTS];
  logic [3*PW-1:0] pos_q;
  logic [3*A-1:0]  acc_q;
  logic            pos_we;
  logic [AW-1:0]   pos_waddr;
  logic [3*PW-1:0] pos_wdata;
  logic [AW-1:0]   pos_raddr;
  logic            acc_we;
  logic [AW-1:0]   acc_waddr;
  logic [3*A-1:0]  acc_wdata;
  logic [AW-1:0]   acc_raddr;

  logic [12:0]     vcount;
  func_t           op;
  logic [AW-1:0]   vaddr;
  logic [AW-1:0]   ca [3];
  logic [1:0]      rcnt;
  logic [1:0]      k;
  logic [AW-1:0]   clr_cnt;
  logic            clr_reply;
  status_t         res_status;

  logic [3*PW-1:0] pa;
  logic [3*PW-1:0] pb;
  logic [3*PW-1:0] pc;
  logic [EMW-1:0]  emag [6];
  logic            eneg [6];
  logic signed [30:0] eop [6];
  logic signed [30:0] mult_a;
  logic signed [30:0] mult_b;
  logic signed [61:0] cprod;
  logic signed [62:0] cr [3];
  logic [2:0]      ccnt;
  logic [1:0]      cdst;
  logic signed [33:0] dif [6];

  logic [MW-1:0]   nm [3];
  logic            nneg [3];
  logic signed [15:0] nvec [3];
  logic            nstart;
  norm_stat_t      nstat;
  logic [QW-1:0]   nq [3];

  logic [3*A-1:0]  acc_sum;
  logic            any_ok;

  function automatic logic idx_ok(input logic [11:0] i, input logic [12:0] vc);
    return (13'(i) < vc) && (32'(i) < 32'(MAX_VERTS));
  endfunction

  svna_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (nstart),
    .mag_in (nm),
    .stat   (nstat),
    .q      (nq)
  );

  assign nstart   = (state == T_NSTART);
  assign in_ready = (state == T_IDLE);

  // memories with registered read
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  assign pos_waddr = AW'(vertex_index);
  assign pos_wdata = {PW'(pos_z), PW'(pos_y), PW'(pos_x)};
  assign pos_we    = (state == T_IDLE) && in_valid && (func == FN_STORE) &&
                     idx_ok(vertex_index, vcount);

  always_comb begin
    case (rcnt)
      2'd0:    pos_raddr = ca[0];
      2'd1:    pos_raddr = ca[1];
      default: pos_raddr = ca[2];
    endcase
  end

  assign acc_raddr = (op == FN_READ) ? vaddr : ca[k];
  assign acc_we    = (state == T_CLEAR) || (state == T_AWR);
  assign acc_waddr = (state == T_CLEAR) ? clr_cnt : ca[k];
  assign acc_wdata = (state == T_CLEAR) ? '0 : acc_sum;

  // saturating add of the unit face normal
  always_comb begin
    logic signed [A:0] s;
    logic signed [A-1:0] cur;
    for (int i = 0; i < 3; i++) begin
      cur = acc_q[i*A +: A];
      s   = (A+1)'(cur) + (A+1)'(nvec[i]);
      if (s[A] != s[A-1]) begin
        acc_sum[i*A +: A] = s[A] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
      end else begin
        acc_sum[i*A +: A] = s[A-1:0];
      end
    end
  end

  // edge differences and signed multiplier operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i]   = 34'(signed'(pb[i*PW +: PW])) - 34'(signed'(pa[i*PW +: PW]));
      dif[i+3] = 34'(signed'(pc[i*PW +: PW])) - 34'(signed'(pa[i*PW +: PW]));
    end
    for (int j = 0; j < 6; j++) begin
      eop[j] = eneg[j] ? -signed'({1'b0, emag[j][29:0]}) : signed'({1'b0, emag[j][29:0]});
    end
  end

  always_comb begin
    case (ccnt)
      3'd0:    begin mult_a = eop[1]; mult_b = eop[5]; end
      3'd1:    begin mult_a = eop[2]; mult_b = eop[4]; end
      3'd2:    begin mult_a = eop[2]; mult_b = eop[3]; end
      3'd3:    begin mult_a = eop[0]; mult_b = eop[5]; end
      3'd4:    begin mult_a = eop[0]; mult_b = eop[4]; end
      default: begin mult_a = eop[1]; mult_b = eop[3]; end
    endcase
  end

  // product issued at step ccnt-1 lands in component (ccnt-1)/2, odd steps subtract
  assign cdst = 2'((ccnt - 3'd1) >> 1);

  assign any_ok = idx_ok(corner_a, vcount) && idx_ok(corner_b, vcount) &&
                  idx_ok(corner_c, vcount);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLEAR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      vcount    <= 13'd4096;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      // the result state reloads the output register itself
      if (out_valid && out_ready && (state != T_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_VERTS - 1)) begin
            state <= clr_reply ? T_RESULT : T_IDLE;
          end
        end
        T_IDLE: begin
          if (in_valid) begin
            op    <= func;
            vaddr <= AW'(vertex_index);
            ca[0] <= AW'(corner_a);
            ca[1] <= AW'(corner_b);
            ca[2] <= AW'(corner_c);
            case (func)
              FN_STORE: begin
                res_status <= idx_ok(vertex_index, vcount) ? ST_OK : ST_RANGE;
                state      <= T_RESULT;
              end
              FN_TRI: begin
                if (any_ok) begin
                  res_status <= ST_OK;
                  rcnt       <= '0;
                  state      <= T_PRD;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= T_RESULT;
                end
              end
              FN_READ: begin
                if (idx_ok(vertex_index, vcount)) begin
                  res_status <= ST_OK;
                  state      <= T_ARD;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= T_RESULT;
                end
              end
              default: begin
                res_status <= ST_OK;
                clr_cnt    <= '0;
                clr_reply  <= 1'b1;
                state      <= T_CLEAR;
              end
            endcase
          end
        end
        T_PRD: begin
          rcnt <= rcnt + 2'd1;
          case (rcnt)
            2'd1:    pa <= pos_q;
            2'd2:    pb <= pos_q;
            2'd3:    pc <= pos_q;
            default: ;
          endcase
          if (rcnt == 2'd3) begin
            state <= T_EDGE;
          end
        end
        T_EDGE: begin
          for (int j = 0; j < 6; j++) begin
            eneg[j] <= dif[j][33];
            emag[j] <= dif[j][33] ? EMW'(-dif[j]) : EMW'(dif[j]);
          end
          state <= T_ESHR;
        end
        T_ESHR: begin
          if ((|emag[0][EMW-1:30]) || (|emag[1][EMW-1:30]) || (|emag[2][EMW-1:30]) ||
              (|emag[3][EMW-1:30]) || (|emag[4][EMW-1:30]) || (|emag[5][EMW-1:30])) begin
            for (int j = 0; j < 6; j++) begin
              emag[j] <= emag[j] >> 1;
            end
          end else begin
            ccnt  <= '0;
            cr[0] <= '0;
            cr[1] <= '0;
            cr[2] <= '0;
            state <= T_CROSS;
          end
        end
        T_CROSS: begin
          cprod <= mult_a * mult_b;
          if (ccnt != 3'd0) begin
            if (ccnt[0]) begin
              cr[cdst] <= cr[cdst] + 63'(cprod);
            end else begin
              cr[cdst] <= cr[cdst] - 63'(cprod);
            end
          end
          ccnt <= ccnt + 3'd1;
          if (ccnt == 3'd6) begin
            state <= T_CMAG;
          end
        end
        T_CMAG: begin
          for (int i = 0; i < 3; i++) begin
            nneg[i] <= cr[i][62];
            nm[i]   <= cr[i][62] ? MW'(-cr[i]) : MW'(cr[i]);
          end
          state <= T_NSTART;
        end
        T_NSTART: state <= T_NWAIT;
        T_NWAIT: begin
          if (nstat.done) begin
            for (int i = 0; i < 3; i++) begin
              nvec[i] <= nneg[i] ? -signed'({1'b0, nq[i]}) : signed'({1'b0, nq[i]});
            end
            k <= '0;
            if (nstat.zero) begin
              res_status <= ST_ZERO;
              state      <= T_RESULT;
            end else if (op == FN_READ) begin
              state <= T_RESULT;
            end else begin
              state <= T_ARD;
            end
          end
        end
        T_ARD: state <= (op == FN_READ) ? T_AGET : T_AWR;
        T_AGET: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [A:0] ext;
            ext     = (A+1)'(signed'(acc_q[i*A +: A]));
            nneg[i] <= ext[A];
            nm[i]   <= ext[A] ? MW'(-ext) : MW'(ext);
          end
          state <= T_NSTART;
        end
        T_AWR: begin
          k <= k + 2'd1;
          state <= (k == 2'd2) ? T_RESULT : T_ARD;
        end
        T_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            if ((op == FN_READ) && (res_status == ST_OK)) begin
              norm_x <= nvec[0];
              norm_y <= nvec[1];
              norm_z <= nvec[2];
            end else begin
              norm_x <= '0;
              norm_y <= '0;
              norm_z <= '0;
            end
            clr_reply <= 1'b0;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb.sv
// self-checking testbench for the smooth vertex normal accumulator
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svna_pkg::*;

  localparam int NVERT      = 4096;
  localparam int ACC_HI     = (1 << 23) - 1;
  localparam int ACC_LO     = -(1 << 23);
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    func_t             fn;
    logic [11:0]       vi;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic [11:0]       ca;
    logic [11:0]       cb;
    logic [11:0]       cc;
  } cmd_t;

  typedef struct packed {
    status_t            st;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } normal_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [12:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  func_t              func = FN_STORE;
  logic [11:0]        vertex_index = '0;
  logic signed [23:0] pos_x = '0;
  logic signed [23:0] pos_y = '0;
  logic signed [23:0] pos_z = '0;
  logic [11:0]        corner_a = '0;
  logic [11:0]        corner_b = '0;
  logic [11:0]        corner_c = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            status;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  smooth_vertex_normal_accumulator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z)
  );

  always #2 clk = ~clk;

  cmd_t        pending_cmds[$];
  normal_res_t expected_normals[$];
  int          errors = 0;
  bit          tail_phase = 1'b0;
  logic        in_fire = 1'b0;

  // mirror of the block state
  logic [12:0] mirror_count = 13'd4096;
  longint      mpos_x[NVERT], mpos_y[NVERT], mpos_z[NVERT];
  longint      macc_x[NVERT], macc_y[NVERT], macc_z[NVERT];

  // generator view: which positions have been stored
  bit          stored[NVERT];
  int          live[$];
  int          gen_count = 4096;

  task automatic report(string what, longint got, longint want);
    $display("tb: mismatch %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic int shift_below(longint unsigned mx);
    int sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    return sh;
  endfunction

  function automatic longint shr_keep(longint v, int sh);
    longint m = longint'(magn(v) >> sh);
    return v < 0 ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_q14(input longint vx, vy, vz, output longint ux, uy, uz);
    longint unsigned mx, sum, len;
    longint w[3];
    longint u[3];
    int sh;
    mx = magn(vx);
    if (magn(vy) > mx) mx = magn(vy);
    if (magn(vz) > mx) mx = magn(vz);
    sh = shift_below(mx);
    w[0] = shr_keep(vx, sh);
    w[1] = shr_keep(vy, sh);
    w[2] = shr_keep(vz, sh);
    sum = 0;
    for (int i = 0; i < 3; i++) sum += magn(w[i]) * magn(w[i]);
    ux = 0; uy = 0; uz = 0;
    if (sum == 0) return 1'b0;
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((magn(w[i]) * 16384 + len / 2) / len);
      if (w[i] < 0) u[i] = -u[i];
    end
    ux = u[0]; uy = u[1]; uz = u[2];
    return 1'b1;
  endfunction

  function automatic longint sat_acc(longint a, longint b);
    longint s = a + b;
    if (s > ACC_HI) s = ACC_HI;
    if (s < ACC_LO) s = ACC_LO;
    return s;
  endfunction

  function automatic bit in_range(int idx);
    return idx < int'(mirror_count) && idx < NVERT;
  endfunction

  task automatic predict_normal(input cmd_t c, output normal_res_t r);
    longint e[6];
    longint cx, cy, cz, ux, uy, uz, mx;
    int sh, a, b, k;
    int corners[3];
    r = '0;
    ux = 0; uy = 0; uz = 0;
    case (c.fn)
      FN_STORE: begin
        if (in_range(c.vi)) begin
          mpos_x[c.vi] = c.px;
          mpos_y[c.vi] = c.py;
          mpos_z[c.vi] = c.pz;
        end else begin
          r.st = ST_RANGE;
        end
      end
      FN_TRI: begin
        if (!in_range(c.ca) || !in_range(c.cb) || !in_range(c.cc)) begin
          r.st = ST_RANGE;
        end else begin
          a = c.ca; b = c.cb; k = c.cc;
          e[0] = mpos_x[b] - mpos_x[a];
          e[1] = mpos_y[b] - mpos_y[a];
          e[2] = mpos_z[b] - mpos_z[a];
          e[3] = mpos_x[k] - mpos_x[a];
          e[4] = mpos_y[k] - mpos_y[a];
          e[5] = mpos_z[k] - mpos_z[a];
          mx = 0;
          for (int i = 0; i < 6; i++) if (magn(e[i]) > mx) mx = magn(e[i]);
          sh = shift_below(mx);
          for (int i = 0; i < 6; i++) e[i] = shr_keep(e[i], sh);
          cx = e[1] * e[5] - e[2] * e[4];
          cy = e[2] * e[3] - e[0] * e[5];
          cz = e[0] * e[4] - e[1] * e[3];
          if (!unit_q14(cx, cy, cz, ux, uy, uz)) begin
            r.st = ST_ZERO;
          end else begin
            corners = '{a, b, k};
            foreach (corners[i]) begin
              macc_x[corners[i]] = sat_acc(macc_x[corners[i]], ux);
              macc_y[corners[i]] = sat_acc(macc_y[corners[i]], uy);
              macc_z[corners[i]] = sat_acc(macc_z[corners[i]], uz);
            end
          end
        end
      end
      FN_READ: begin
        if (!in_range(c.vi)) begin
          r.st = ST_RANGE;
        end else if (!unit_q14(macc_x[c.vi], macc_y[c.vi], macc_z[c.vi], ux, uy, uz)) begin
          r.st = ST_ZERO;
        end else begin
          r.nx = ux[15:0];
          r.ny = uy[15:0];
          r.nz = uz[15:0];
        end
      end
      default: begin
        for (int i = 0; i < NVERT; i++) begin
          macc_x[i] = 0; macc_y[i] = 0; macc_z[i] = 0;
        end
      end
    endcase
  endtask

  // monitor, scoreboard and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    cmd_t        c;
    normal_res_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_we) mirror_count = cfg_wdata;
      if (in_valid && in_ready) begin
        c = '{func, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c};
        predict_normal(c, want);
        expected_normals = {expected_normals, want};
      end
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          report("unexpected beat, status", status, 0);
        end else begin
          want = expected_normals.pop_front();
          if (status !== want.st) report("status", status, want.st);
          if (norm_x !== want.nx) report("norm_x", norm_x, want.nx);
          if (norm_y !== want.ny) report("norm_y", norm_y, want.ny);
          if (norm_z !== want.nz) report("norm_z", norm_z, want.nz);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // command driver
  int send_gap = 0;
  always @(negedge clk) begin
    cmd_t c;
    if (!(in_valid && !in_fire)) begin
      if (in_fire && !tail_phase && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        func <= c.fn; vertex_index <= c.vi;
        pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz;
        corner_a <= c.ca; corner_b <= c.cb; corner_c <= c.cc;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic cmd_t noise_cmd(func_t fn);
    cmd_t c;
    c.fn = fn;
    c.vi = 12'($urandom); c.ca = 12'($urandom); c.cb = 12'($urandom); c.cc = 12'($urandom);
    c.px = 24'($urandom); c.py = 24'($urandom); c.pz = 24'($urandom);
    return c;
  endfunction

  task automatic push_store(int idx, int x, int y, int z);
    cmd_t c = noise_cmd(FN_STORE);
    c.vi = idx[11:0]; c.px = x[23:0]; c.py = y[23:0]; c.pz = z[23:0];
    if (idx < gen_count && !stored[idx]) begin
      stored[idx] = 1'b1;
      live = {live, idx};
    end
    queue_cmd(c);
  endtask

  task automatic push_tri(int a, int b, int k);
    cmd_t c = noise_cmd(FN_TRI);
    c.ca = a[11:0]; c.cb = b[11:0]; c.cc = k[11:0];
    queue_cmd(c);
  endtask

  task automatic push_read(int idx);
    cmd_t c = noise_cmd(FN_READ);
    c.vi = idx[11:0];
    queue_cmd(c);
  endtask

  // waits until the block has drained, then writes vertex_count
  task automatic set_count(int v);
    wait (pending_cmds.size() == 0 && !in_valid && expected_normals.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[12:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_count = v > NVERT ? NVERT : v;
    live.delete();
    for (int i = 0; i < gen_count; i++) if (stored[i]) live = {live, i};
  endtask

  // a corner that is either stored and in range, or deliberately out of range
  function automatic int pick_corner();
    if (gen_count < NVERT && $urandom_range(0, 15) == 0) return $urandom_range(gen_count, NVERT - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8191) - 4096;
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  task automatic gen_random(int n);
    int r, idx, a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (live.size() == 0 || r < 25) begin
        if (gen_count < NVERT && $urandom_range(0, 9) == 0) idx = $urandom_range(gen_count, NVERT - 1);
        else idx = $urandom_range(0, gen_count - 1);
        push_store(idx, rand_coord(), rand_coord(), rand_coord());
      end else if (r < 70) begin
        a = pick_corner();
        // repeated corners make a degenerate face now and then
        if ($urandom_range(0, 12) == 0) push_tri(a, a, pick_corner());
        else push_tri(a, pick_corner(), pick_corner());
      end else if (r < 99) begin
        if (gen_count < NVERT && $urandom_range(0, 9) == 0) idx = $urandom_range(gen_count, NVERT - 1);
        else if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, gen_count - 1);
        else idx = live[$urandom_range(0, live.size() - 1)];
        push_read(idx);
      end else begin
        queue_cmd(noise_cmd(FN_CLEAR));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (in_ready);

    // directed: extremes, every operation, degenerate and zero-length cases
    set_count(4096);
    push_store(0, 0, 0, 0);
    push_store(1, 8388607, 0, -8388608);
    push_store(2, -8388608, 8388607, 0);
    push_store(4095, 4096, 4096, 8388607);
    push_tri(0, 1, 2);
    push_tri(0, 0, 1);
    push_store(3, 16, 16, 16);
    push_store(4, 32, 32, 32);
    push_tri(0, 3, 4);
    push_tri(4095, 1, 2);
    push_read(0);
    push_read(4095);
    push_read(5);
    queue_cmd(noise_cmd(FN_CLEAR));
    push_read(0);
    push_tri(2, 1, 0);
    push_read(1);

    set_count(1);
    push_store(0, -5, 7, 9);
    push_store(1, 1, 1, 1);
    push_tri(0, 0, 0);
    push_tri(0, 1, 2);
    push_read(1);
    push_read(0);

    set_count(0);
    push_store(0, 1, 2, 3);
    push_read(0);
    push_tri(0, 0, 0);
    queue_cmd(noise_cmd(FN_CLEAR));

    set_count(8191);
    push_tri(4095, 0, 1);
    push_read(4095);
    push_read(2);

    // pile one face normal onto three vertices until the accumulators clamp
    set_count(3);
    push_store(0, 0, 0, 0);
    push_store(1, 4096, 0, 0);
    push_store(2, 0, 4096, 0);
    for (int i = 0; i < 514; i++) push_tri(0, 1, 2);
    push_store(1, 0, 0, 4096);
    for (int i = 0; i < 4; i++) push_tri(0, 1, 2);
    push_read(0);
    push_read(1);
    push_read(2);

    set_count(64);
    gen_random(6);
    set_count(4096);
    gen_random(6);
    set_count(8191);
    tail_phase = 1'b1;
    gen_random(6);

    wait (pending_cmds.size() == 0 && !in_valid && expected_normals.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
